### rtl/task_slot_round_robin_scheduler_macros.svh
// assertion macros used by the scheduler datapath
`ifndef TASK_SLOT_ROUND_ROBIN_SCHEDULER_MACROS_SVH
`define TASK_SLOT_ROUND_ROBIN_SCHEDULER_MACROS_SVH

`ifndef SYNTH
`define TSRR_ASSERT_ALWAYS(label, expr) \
  label: assert property (@(posedge clk) disable iff (rst) (expr)) \
    else $error("tsrr invariant violated");
`define TSRR_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("tsrr sequence violated");
`else
`define TSRR_ASSERT_ALWAYS(label, expr)
`define TSRR_ASSERT_NEXT(label, ante, cons)
`endif

`endif

### rtl/tsrr_pkg.sv
`default_nettype none

package tsrr_pkg;

  // command codes
  localparam logic [2:0] CMD_CREATE = 3'd0;
  localparam logic [2:0] CMD_YIELD  = 3'd1;
  localparam logic [2:0] CMD_KILL   = 3'd2;
  localparam logic [2:0] CMD_JOIN   = 3'd3;
  localparam logic [2:0] CMD_DONE   = 3'd4;

  // result status codes
  localparam logic [2:0] ST_OK   = 3'd0;
  localparam logic [2:0] ST_FULL = 3'd1;
  localparam logic [2:0] ST_NONE = 3'd2;
  localparam logic [2:0] ST_BUSY = 3'd3;
  localparam logic [2:0] ST_IGN  = 3'd4;

  typedef enum logic [3:0] {
    DP_NOP,
    DP_LOAD,
    DP_FREE_INIT,
    DP_YIELD_INIT,
    DP_DONE_INIT,
    DP_JOIN_BUSY,
    DP_KILL,
    DP_JOIN,
    DP_IGNORE,
    DP_STEP,
    DP_ALLOC,
    DP_FULL,
    DP_SWITCH,
    DP_MISS
  } dp_op_t;

  typedef struct packed {
    logic is_create;
    logic is_yield;
    logic is_kill;
    logic is_join;
    logic is_done;
    logic join_ign;
    logic join_busy;
    logic hit_free;
    logic hit_run;
    logic scan_last;
  } dp_status_t;

endpackage

`default_nettype wire

### rtl/tsrr_ifs.sv
`default_nettype none

interface tsrr_cmd_if;
  logic       valid;
  logic       ready;
  logic [2:0] command;
  logic [2:0] slot;
  logic       joinable;

  modport source (output valid, command, slot, joinable, input ready);
  modport sink (input valid, command, slot, joinable, output ready);
endinterface

interface tsrr_rsp_if;
  logic       valid;
  logic       ready;
  logic [2:0] status;
  logic [2:0] slot_out;
  logic [2:0] current;

  modport source (output valid, status, slot_out, current, input ready);
  modport sink (input valid, status, slot_out, current, output ready);
endinterface

`default_nettype wire

### rtl/tsrr_datapath.sv
`default_nettype none

module tsrr_datapath #(
  parameter int SLOTS = 8
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire tsrr_pkg::dp_op_t    op,
  input  wire logic [2:0]          command,
  input  wire logic [2:0]          slot,
  input  wire logic                joinable,
  output tsrr_pkg::dp_status_t     stat,
  output logic [2:0]               status,
  output logic [2:0]               slot_out,
  output logic [2:0]               current
);

  localparam int IW = $clog2(SLOTS);
  localparam logic [IW-1:0] LAST = IW'(SLOTS - 1);

  logic [SLOTS-1:0] used;
  logic [SLOTS-1:0] runnable;
  logic [SLOTS-1:0] joinable_marks;
  logic [IW-1:0]    cur;

  logic [2:0]       cmd_q;
  logic [2:0]       slot_q;
  logic             jn_q;
  logic [IW-1:0]    ptr;
  logic [IW-1:0]    cnt;
  logic [2:0]       status_q;
  logic [2:0]       so_q;

  logic [IW-1:0]    slot_idx;
  logic             slot_ok;
  logic [IW-1:0]    cur_inc;
  logic [IW-1:0]    ptr_inc;

  function automatic logic [IW-1:0] wrap_inc(input logic [IW-1:0] v);
    return (v == LAST) ? '0 : v + 1'b1;
  endfunction

  assign slot_idx = IW'(slot_q);
  assign slot_ok  = 32'(slot_q) < SLOTS;
  assign cur_inc  = wrap_inc(cur);
  assign ptr_inc  = wrap_inc(ptr);

  always_comb begin
    stat.is_create = cmd_q == tsrr_pkg::CMD_CREATE;
    stat.is_yield  = cmd_q == tsrr_pkg::CMD_YIELD;
    stat.is_kill   = cmd_q == tsrr_pkg::CMD_KILL;
    stat.is_join   = cmd_q == tsrr_pkg::CMD_JOIN;
    stat.is_done   = cmd_q == tsrr_pkg::CMD_DONE;
    stat.join_ign  = !slot_ok || (slot_idx == cur);
    stat.join_busy = runnable[slot_idx];
    stat.hit_free  = !used[ptr];
    stat.hit_run   = runnable[ptr];
    stat.scan_last = cnt == LAST;
  end

  // slot marks and current task
  always_ff @(posedge clk) begin
    if (rst) begin
      used           <= SLOTS'(1);
      runnable       <= SLOTS'(1);
      joinable_marks <= '0;
      cur            <= '0;
    end else begin
      case (op)
        tsrr_pkg::DP_DONE_INIT: begin
          // slot 0 is never stopped
          if (cur != '0) begin
            runnable[cur] <= 1'b0;
            if (!joinable_marks[cur]) used[cur] <= 1'b0;
          end
        end
        tsrr_pkg::DP_KILL: begin
          if (slot_ok && slot_q != 3'd0) begin
            runnable[slot_idx] <= 1'b0;
            if (!joinable_marks[slot_idx]) used[slot_idx] <= 1'b0;
          end
        end
        tsrr_pkg::DP_JOIN: begin
          used[slot_idx]           <= 1'b0;
          joinable_marks[slot_idx] <= 1'b0;
        end
        tsrr_pkg::DP_ALLOC: begin
          used[ptr]           <= 1'b1;
          runnable[ptr]       <= 1'b1;
          joinable_marks[ptr] <= jn_q;
        end
        tsrr_pkg::DP_SWITCH: cur <= ptr;
        default: ;
      endcase
    end
  end

  // request latch, scan pointer and result registers
  always_ff @(posedge clk) begin
    case (op)
      tsrr_pkg::DP_LOAD: begin
        cmd_q  <= command;
        slot_q <= slot;
        jn_q   <= joinable;
      end
      tsrr_pkg::DP_FREE_INIT: begin
        ptr <= '0;
        cnt <= '0;
      end
      tsrr_pkg::DP_YIELD_INIT, tsrr_pkg::DP_DONE_INIT: begin
        ptr      <= cur_inc;
        cnt      <= '0;
        so_q     <= 3'(cur);
        status_q <= tsrr_pkg::ST_OK;
      end
      tsrr_pkg::DP_JOIN_BUSY: begin
        ptr      <= cur_inc;
        cnt      <= '0;
        so_q     <= slot_q;
        status_q <= tsrr_pkg::ST_BUSY;
      end
      tsrr_pkg::DP_KILL: begin
        so_q     <= slot_q;
        status_q <= (slot_ok && slot_q != 3'd0) ? tsrr_pkg::ST_OK : tsrr_pkg::ST_IGN;
      end
      tsrr_pkg::DP_JOIN: begin
        so_q     <= slot_q;
        status_q <= tsrr_pkg::ST_OK;
      end
      tsrr_pkg::DP_IGNORE: begin
        so_q     <= slot_q;
        status_q <= tsrr_pkg::ST_IGN;
      end
      tsrr_pkg::DP_STEP: begin
        ptr <= ptr_inc;
        cnt <= cnt + 1'b1;
      end
      tsrr_pkg::DP_ALLOC: begin
        so_q     <= 3'(ptr);
        status_q <= tsrr_pkg::ST_OK;
      end
      tsrr_pkg::DP_FULL: begin
        so_q     <= 3'd0;
        status_q <= tsrr_pkg::ST_FULL;
      end
      tsrr_pkg::DP_SWITCH: begin
        if (cmd_q == tsrr_pkg::CMD_YIELD) so_q <= 3'(ptr);
      end
      tsrr_pkg::DP_MISS: begin
        // a join keeps its busy answer even when nothing else runs
        if (cmd_q != tsrr_pkg::CMD_JOIN) status_q <= tsrr_pkg::ST_NONE;
      end
      default: ;
    endcase
  end

  assign status   = status_q;
  assign slot_out = so_q;
  assign current  = 3'(cur);

`include "task_slot_round_robin_scheduler_macros.svh"

  `TSRR_ASSERT_ALWAYS(a_main_task_live, used[0] && runnable[0])
  `TSRR_ASSERT_ALWAYS(a_runnable_used, (runnable & ~used) == '0)
  `TSRR_ASSERT_ALWAYS(a_joinable_used, (joinable_marks & ~used) == '0)
  `TSRR_ASSERT_ALWAYS(a_current_range, cur <= LAST)
  `TSRR_ASSERT_NEXT(a_switch_runnable, op == tsrr_pkg::DP_SWITCH, runnable[cur])

endmodule

`default_nettype wire

### rtl/tsrr_ctrl.sv
`default_nettype none

module tsrr_ctrl (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 in_valid,
  output logic                      in_ready,
  output logic                      out_valid,
  input  wire logic                 out_ready,
  input  wire tsrr_pkg::dp_status_t stat,
  output tsrr_pkg::dp_op_t          op
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_DISPATCH,
    S_FREE,
    S_YIELD,
    S_OUT
  } state_t;

  state_t state;
  state_t state_next;

  assign in_ready  = state == S_IDLE;
  assign out_valid = state == S_OUT;

  always_comb begin
    op         = tsrr_pkg::DP_NOP;
    state_next = state;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          op         = tsrr_pkg::DP_LOAD;
          state_next = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        if (stat.is_create) begin
          op         = tsrr_pkg::DP_FREE_INIT;
          state_next = S_FREE;
        end else if (stat.is_yield) begin
          op         = tsrr_pkg::DP_YIELD_INIT;
          state_next = S_YIELD;
        end else if (stat.is_done) begin
          op         = tsrr_pkg::DP_DONE_INIT;
          state_next = S_YIELD;
        end else if (stat.is_kill) begin
          op         = tsrr_pkg::DP_KILL;
          state_next = S_OUT;
        end else if (stat.is_join && !stat.join_ign && stat.join_busy) begin
          // target still running: give up the slot by one yield
          op         = tsrr_pkg::DP_JOIN_BUSY;
          state_next = S_YIELD;
        end else if (stat.is_join && !stat.join_ign) begin
          op         = tsrr_pkg::DP_JOIN;
          state_next = S_OUT;
        end else begin
          op         = tsrr_pkg::DP_IGNORE;
          state_next = S_OUT;
        end
      end
      S_FREE: begin
        if (stat.hit_free) begin
          op         = tsrr_pkg::DP_ALLOC;
          state_next = S_OUT;
        end else if (stat.scan_last) begin
          op         = tsrr_pkg::DP_FULL;
          state_next = S_OUT;
        end else begin
          op = tsrr_pkg::DP_STEP;
        end
      end
      S_YIELD: begin
        if (stat.hit_run) begin
          op         = tsrr_pkg::DP_SWITCH;
          state_next = S_OUT;
        end else if (stat.scan_last) begin
          op         = tsrr_pkg::DP_MISS;
          state_next = S_OUT;
        end else begin
          op = tsrr_pkg::DP_STEP;
        end
      end
      S_OUT: begin
        if (out_ready) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

`default_nettype wire

### rtl/task_slot_round_robin_scheduler.sv
// round-robin task slot scheduler
// cmd channel: one request per command (create, yield, kill, join, done)
//   carrying command, slot and joinable; accepted when valid and ready
// rsp channel: exactly one result per request with status, slot_out and
//   current, the index of the current task after the command
// one request is in flight at a time; cmd ready is high only while idle
// kill, join of a stopped slot and ignored commands pass from dispatch
//   straight to the result; create, yield, done and join of a running
//   slot first run the slot scan, which tests one slot per cycle, from
//   slot 0 for create and from the slot after the current task otherwise
// a stalled rsp holds the result registered until taken; no new request is
//   accepted meanwhile
// reset: slot 0 used and runnable, all other slots free, current task 0,
//   no result pending
`default_nettype none

module task_slot_round_robin_scheduler #(
  parameter int SLOTS = 8
) (
  input  wire logic   clk,
  input  wire logic   rst,
  tsrr_cmd_if.sink    cmd,
  tsrr_rsp_if.source  rsp
);

  tsrr_pkg::dp_op_t     op;
  tsrr_pkg::dp_status_t stat;

  tsrr_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (cmd.valid),
    .in_ready  (cmd.ready),
    .out_valid (rsp.valid),
    .out_ready (rsp.ready),
    .stat      (stat),
    .op        (op)
  );

  tsrr_datapath #(
    .SLOTS (SLOTS)
  ) u_datapath (
    .clk      (clk),
    .rst      (rst),
    .op       (op),
    .command  (cmd.command),
    .slot     (cmd.slot),
    .joinable (cmd.joinable),
    .stat     (stat),
    .status   (rsp.status),
    .slot_out (rsp.slot_out),
    .current  (rsp.current)
  );

endmodule

`default_nettype wire
